>>> src/ssm_pkg.sv
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int CAPACITY  = 64;
  localparam int ID_WORDS  = 4;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 32;
  localparam int WORD_W    = 16;
  localparam int TAG_WORDS = 4;
  localparam int TAG_W     = WORD_W * TAG_WORDS;
  localparam int ENTRY_W   = KEY_W + TAG_W;
  localparam int IDW_W     = 3;

  typedef logic [2:0]               cmd_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [KEY_W-1:0]  key_t;
  typedef logic [TAG_W-1:0]         tag_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [IDW_W-1:0]         idw_t;

  localparam cmd_t CMD_INSERT      = 3'd0;
  localparam cmd_t CMD_PEEK_MAX    = 3'd1;
  localparam cmd_t CMD_PEEK_MEDIAN = 3'd2;
  localparam cmd_t CMD_PEEK_MIN    = 3'd3;
  localparam cmd_t CMD_POP_MAX     = 3'd4;
  localparam cmd_t CMD_POP_MIN     = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_DUP   = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage

>>> src/sorted_set_with_median.sv
`timescale 1ns / 1ps
// Peeks and pop min read one entry; pop max also moves each remaining entry toward the
// maximum; insert scans every entry, then moves those at and after its position toward
// the minimum (none move when the insert is rejected or goes last, and into an empty set
// it is written at once); a held result stalls the block. It takes one transaction at a
// time, paced by the one read and one write port of the entry RAM.
// Synchronous active-low reset empties the set and sets id_words to 4; RAM is not cleared.
module sorted_set_with_median (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssm_pkg::cmd_t    in_command,
  input  ssm_pkg::key_t    in_key,
  input  ssm_pkg::tag_t    in_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output ssm_pkg::status_t out_status,
  output ssm_pkg::key_t    out_result_key,
  output ssm_pkg::tag_t    out_result_tag,
  output ssm_pkg::count_t  out_count,
  input  logic             cfg_we,
  input  ssm_pkg::idw_t    cfg_wdata
);

  import ssm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_SHUP   = 4'd3;
  localparam logic [3:0] S_WRITE  = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_SHDN   = 4'd6;
  localparam logic [3:0] S_RESP   = 4'd7;

  logic [3:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  key_t              key_r, key_nxt;
  tag_t              tag_r, tag_nxt;
  count_t            cnt_r, cnt_nxt;
  idw_t              idw_r, idw_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  count_t            pos_r, pos_nxt;
  logic              dup_r, dup_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  status_t           res_status_r, res_status_nxt;
  key_t              res_key_r, res_key_nxt;
  tag_t              res_tag_r, res_tag_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  key_t              out_key_r, out_key_nxt;
  tag_t              out_tag_r, out_tag_nxt;
  count_t            out_count_r, out_count_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  key_t              rd_key;
  tag_t              rd_tag;
  count_t            cnt_m1;
  logic [ADDR_W-1:0] sel_idx;
  logic [2:0]        n_words;
  logic              tag_eq;
  logic              match;
  logic              greater;

  ssm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[ENTRY_W-1:TAG_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];
  assign cnt_m1 = cnt_r - count_t'(1);

  // Only the first id_words tag words take part; larger settings saturate.
  always_comb begin
    n_words = (idw_r > 3'(TAG_WORDS)) ? 3'(TAG_WORDS) : idw_r;
    tag_eq  = 1'b1;
    for (int w = 0; w < TAG_WORDS; w++) begin
      if ((3'(w) < n_words) &&
          (rd_tag[w*WORD_W +: WORD_W] != tag_r[w*WORD_W +: WORD_W])) begin
        tag_eq = 1'b0;
      end
    end
  end

  assign match   = (rd_key == key_r) && tag_eq;
  assign greater = (rd_key > key_r);

  always_comb begin
    unique case (in_command)
      CMD_PEEK_MEDIAN: sel_idx = cnt_m1[ADDR_W:1];
      CMD_PEEK_MIN,
      CMD_POP_MIN:     sel_idx = cnt_m1[ADDR_W-1:0];
      default:         sel_idx = '0;
    endcase
  end

  assign idw_nxt = cfg_we ? cfg_wdata : idw_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    tag_nxt        = tag_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    pos_nxt        = pos_r;
    dup_nxt        = dup_r;
    ptr_nxt        = ptr_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = {key_r, tag_r};
    ram_raddr      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          key_nxt        = in_key;
          tag_nxt        = in_tag;
          res_status_nxt = ST_OK;
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          priority if (in_command == CMD_INSERT) begin
            pos_nxt  = '0;
            dup_nxt  = 1'b0;
            scan_nxt = '0;
            state_nxt = (cnt_r == '0) ? S_WRITE : S_SCAN;
          end else if (in_command > CMD_POP_MIN) begin
            state_nxt = S_RESP;
          end else if (cnt_r == '0) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_RESP;
          end else begin
            ram_raddr = sel_idx;
            state_nxt = S_READ;
          end
        end
      end
      S_SCAN: begin
        // Position is the number of stored keys strictly above the new one.
        dup_nxt = dup_r | match;
        pos_nxt = pos_r + count_t'(greater);
        if (count_t'(scan_r) + count_t'(1) < cnt_r) begin
          ram_raddr = scan_r + ADDR_W'(1);
          scan_nxt  = scan_r + ADDR_W'(1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (dup_r) begin
          res_status_nxt = ST_DUP;
          state_nxt      = S_RESP;
        end else if (cnt_r == count_t'(CAPACITY)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else if (pos_r == cnt_r) begin
          state_nxt = S_WRITE;
        end else begin
          ptr_nxt   = cnt_m1[ADDR_W-1:0];
          ram_raddr = cnt_m1[ADDR_W-1:0];
          state_nxt = S_SHUP;
        end
      end
      S_SHUP: begin
        // Move entries one slot toward the minimum, last entry first.
        ram_we    = 1'b1;
        ram_waddr = ptr_r + ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (count_t'(ptr_r) > pos_r) begin
          ram_raddr = ptr_r - ADDR_W'(1);
          ptr_nxt   = ptr_r - ADDR_W'(1);
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[ADDR_W-1:0];
        ram_wdata = {key_r, tag_r};
        cnt_nxt   = cnt_r + count_t'(1);
        state_nxt = S_RESP;
      end
      S_READ: begin
        res_key_nxt = rd_key;
        res_tag_nxt = rd_tag;
        priority if ((cmd_r == CMD_POP_MAX) && (cnt_r > count_t'(1))) begin
          ram_raddr = ADDR_W'(1);
          ptr_nxt   = ADDR_W'(1);
          state_nxt = S_SHDN;
        end else if ((cmd_r == CMD_POP_MAX) || (cmd_r == CMD_POP_MIN)) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SHDN: begin
        // Close the gap left by the maximum, first entry first.
        ram_we    = 1'b1;
        ram_waddr = ptr_r - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (count_t'(ptr_r) + count_t'(1) < cnt_r) begin
          ram_raddr = ptr_r + ADDR_W'(1);
          ptr_nxt   = ptr_r + ADDR_W'(1);
        end else begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_tag_nxt    = res_tag_r;
          out_count_nxt  = cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idw_r       <= idw_t'(ID_WORDS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idw_r       <= idw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    tag_r        <= tag_nxt;
    scan_r       <= scan_nxt;
    pos_r        <= pos_nxt;
    dup_r        <= dup_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_tag_r    <= out_tag_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_result_key = out_key_r;
  assign out_result_tag = out_tag_r;
  assign out_count      = out_count_r;

endmodule

>>> src/ssm_ram.sv
`timescale 1ns / 1ps

module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
